// ----- rtl/sme_pkg.sv -----
// Shared types, opcodes and constants for the stack machine executor.
package sme_pkg;

  localparam int unsigned StackDepthDefault = 1024;
  localparam int unsigned DataWordsDefault  = 1024;
  localparam int unsigned CodeWordsDefault  = 1024;

  localparam int unsigned OpW    = 5;
  localparam int unsigned AddrW  = 10;
  localparam int unsigned WordW  = 32;
  localparam int unsigned FaultW = 2;

  typedef enum logic [OpW-1:0] {
    OP_NOP   = 5'd0,  OP_LOAD  = 5'd1,  OP_LOADI = 5'd2,  OP_STO  = 5'd3,
    OP_POP   = 5'd4,  OP_ADD   = 5'd5,  OP_SUB   = 5'd6,  OP_MULT = 5'd7,
    OP_DIV   = 5'd8,  OP_BR    = 5'd9,  OP_BRF   = 5'd10, OP_EQ   = 5'd11,
    OP_NOTEQ = 5'd12, OP_GT    = 5'd13, OP_LES   = 5'd14, OP_GE   = 5'd15,
    OP_LE    = 5'd16, OP_AND   = 5'd17, OP_OR    = 5'd18, OP_NOT  = 5'd19,
    OP_IN    = 5'd20, OP_OUT   = 5'd21, OP_STOP  = 5'd22
  } opcode_e;

  typedef enum logic [FaultW-1:0] {
    FLT_NONE = 2'd0, FLT_UNDER = 2'd1, FLT_OVER = 2'd2, FLT_DIVZ = 2'd3
  } fault_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_WB, ST_RESP
  } state_e;

  // Datapath commands from the controller.
  typedef struct packed {
    logic latch;      // capture input beat
    logic clr_step;   // write zero to data memory at clear counter
    logic rd_top;     // read stack[sp-1], data[addr]
    logic rd_sec;     // read stack[sp-2]
    logic exec;       // evaluate instruction
    logic div_start;
    logic commit;     // write back, update pc/sp
    logic resp_load;  // load output register
  } cmd_t;

  // Status to the controller.
  typedef struct packed {
    logic clr_done;
    logic halted;
    logic needs_div;  // div with operands ok
    logic div_done;
    logic out_taken;
  } sts_t;

endpackage

// ----- rtl/stack_machine_executor_unit.sv -----
// Top level of the stack machine executor.
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | opcode, address, immediate, in_value
//  out     | output    | out_valid_o/out_stall_i | next_pc, out_valid, out_value, halted, fault
// One instruction at a time: after its input beat come the two stack reads, execute, for div
// the 32-step bit-serial divider, then write-back and the result beat.
// The next input beat can be taken the cycle after the result beat is taken.
// After reset a pass clears data memory before input is taken.
// A stalled result holds in the output register; input waits until it is taken.
module stack_machine_executor_unit #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDefault,
  parameter int unsigned DATA_WORDS  = sme_pkg::DataWordsDefault,
  parameter int unsigned CODE_WORDS  = sme_pkg::CodeWordsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sme_pkg::OpW-1:0]     opcode_i,
  input  logic [sme_pkg::AddrW-1:0]   address_i,
  input  logic [sme_pkg::WordW-1:0]   immediate_i,
  input  logic [sme_pkg::WordW-1:0]   in_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sme_pkg::AddrW-1:0]   next_pc_o,
  output logic                        out_valid_flag_o,
  output logic [sme_pkg::WordW-1:0]   out_value_o,
  output logic                        halted_o,
  output logic [sme_pkg::FaultW-1:0]  fault_o
);
  sme_pkg::cmd_t cmd;
  sme_pkg::sts_t sts;

  sme_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  sme_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .DATA_WORDS(DATA_WORDS), .CODE_WORDS(CODE_WORDS)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .out_stall_i,
    .opcode_i, .address_i, .immediate_i, .in_value_i,
    .next_pc_o, .out_valid_o(out_valid_flag_o), .out_value_o, .halted_o, .fault_o
  );
endmodule

// ----- rtl/sme_divider.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle.
module sme_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sme_pkg::WordW-1:0]  num_i,
  input  logic [sme_pkg::WordW-1:0]  den_i,
  output logic                       done_o,
  output logic [sme_pkg::WordW-1:0]  quo_o
);
  localparam int unsigned W = sme_pkg::WordW;
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]   cnt_q, cnt_d;
  logic         neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [W:0]   trial;
  logic [W-1:0] shr;

  // One restoring step per cycle.
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q; done_d = 1'b0;
    shr   = {rem_q[W-2:0], quo_q[W-1]};
    trial = {1'b0, shr} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[W-1] ? (~num_i + W'(1)) : num_i;
      den_d  = den_i[W-1] ? (~den_i + W'(1)) : den_i;
      neg_d  = num_i[W-1] ^ den_i[W-1];
      cnt_d  = 6'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = trial[W] ? shr : trial[W-1:0];
      quo_d = {quo_q[W-2:0], ~trial[W]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? (~quo_q + W'(1)) : quo_q;
endmodule

// ----- rtl/sme_ctrl.sv -----
// Controller state machine sequencing one instruction at a time.
module sme_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  sme_pkg::sts_t   sts_i,
  output sme_pkg::cmd_t   cmd_o
);
  sme_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sme_pkg::ST_CLEAR;
    else         state_q <= state_d;
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      sme_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = sme_pkg::ST_IDLE;
      end
      sme_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = sme_pkg::ST_RD1;
        end
      end
      sme_pkg::ST_RD1: begin
        cmd_o.rd_top = 1'b1;
        state_d = sme_pkg::ST_RD2;
      end
      sme_pkg::ST_RD2: begin
        cmd_o.rd_sec = 1'b1;
        state_d = sme_pkg::ST_EXEC;
      end
      sme_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.needs_div) begin
          cmd_o.div_start = 1'b1;
          state_d = sme_pkg::ST_DIV;
        end else begin
          state_d = sme_pkg::ST_WB;
        end
      end
      sme_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = sme_pkg::ST_WB;
      end
      sme_pkg::ST_WB: begin
        cmd_o.commit    = 1'b1;
        cmd_o.resp_load = 1'b1;
        state_d = sme_pkg::ST_RESP;
      end
      sme_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
        if (sts_i.out_taken) state_d = sme_pkg::ST_IDLE;
      end
      default: state_d = sme_pkg::ST_IDLE;
    endcase
  end
endmodule

// ----- rtl/sme_datapath.sv -----
// Datapath: stack and data memories, pc, sp, ALU and result register.
module sme_datapath #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDefault,
  parameter int unsigned DATA_WORDS  = sme_pkg::DataWordsDefault,
  parameter int unsigned CODE_WORDS  = sme_pkg::CodeWordsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sme_pkg::cmd_t               cmd_i,
  output sme_pkg::sts_t               sts_o,
  input  logic                        out_stall_i,
  input  logic [sme_pkg::OpW-1:0]     opcode_i,
  input  logic [sme_pkg::AddrW-1:0]   address_i,
  input  logic [sme_pkg::WordW-1:0]   immediate_i,
  input  logic [sme_pkg::WordW-1:0]   in_value_i,
  output logic [sme_pkg::AddrW-1:0]   next_pc_o,
  output logic                        out_valid_o,
  output logic [sme_pkg::WordW-1:0]   out_value_o,
  output logic                        halted_o,
  output logic [sme_pkg::FaultW-1:0]  fault_o
);
  localparam int unsigned W   = sme_pkg::WordW;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned DAW = $clog2(DATA_WORDS);
  localparam int unsigned PCW = $clog2(CODE_WORDS);
  localparam int unsigned AW  = sme_pkg::AddrW;

  logic [W-1:0] stack_mem [STACK_DEPTH];
  logic [W-1:0] data_mem  [DATA_WORDS];

  // Latched instruction.
  logic [sme_pkg::OpW-1:0] op_q;
  logic [AW-1:0]           addr_q;
  logic [W-1:0]            imm_q, inv_q;
  logic [W-1:0]            top_q, sec_q, dmem_q;
  logic [PCW-1:0]          pc_q, npc_q;
  logic [SPW-1:0]          sp_q, nsp_q;
  logic                    halt_q, swr_q, swr_d, dwr_q, dwr_d;
  logic [SAW-1:0]          swa_q, swa_d;
  logic [sme_pkg::FaultW-1:0] flt_q, sflt_q, flt_d;
  logic                    halt_d, ov_q, ov_d;
  logic [PCW-1:0]          npc_d;
  logic [SPW-1:0]          nsp_d;
  logic [W-1:0]            res_d;
  logic [DAW:0]            clr_q;
  logic [DAW-1:0]          daddr;
  logic [SAW-1:0]          top_a, sec_a;
  logic [PCW-1:0]          pc1, pc2, tgt;
  logic [W-1:0]            mul_q, quo;
  logic                    div_done, was_halt_q;
  logic                    under1, under2, full;
  logic [W-1:0]            sa, sb;

  // Output register.
  logic [AW-1:0]  o_pc_q;
  logic           o_ov_q, o_h_q;
  logic [W-1:0]   o_val_q;
  logic [sme_pkg::FaultW-1:0] o_f_q;

  assign daddr = DAW'(addr_q);
  assign top_a = SAW'(sp_q - SPW'(1));
  assign sec_a = SAW'(sp_q - SPW'(2));
  assign pc1   = PCW'((PCW+1)'(pc_q) + (PCW+1)'(1));
  assign pc2   = PCW'((PCW+1)'(pc_q) + (PCW+1)'(2));
  assign tgt   = PCW'((PCW+1)'(addr_q) + (PCW+1)'(1));
  assign under1 = (sp_q < SPW'(1));
  assign under2 = (sp_q < SPW'(2));
  assign full   = (sp_q >= SPW'(STACK_DEPTH));
  assign sa = top_q ^ {1'b1, {(W-1){1'b0}}};
  assign sb = sec_q ^ {1'b1, {(W-1){1'b0}}};

  // Input capture and clear counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + (DAW+1)'(1);
    end
  end
  assign sts_o.clr_done = (clr_q == (DAW+1)'(DATA_WORDS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= opcode_i; addr_q <= address_i; imm_q <= immediate_i; inv_q <= in_value_i;
    end
  end

  // Memory reads: top+data, then second.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_top) begin
      top_q  <= stack_mem[top_a];
      dmem_q <= data_mem[daddr];
    end
    if (cmd_i.rd_sec) begin
      sec_q <= stack_mem[sec_a];
    end
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) data_mem[clr_q[DAW-1:0]] <= '0;
    else if (cmd_i.commit && dwr_q) data_mem[daddr] <= top_q;
    if (cmd_i.commit && swr_q) stack_mem[swa_q] <= res_d;
  end

  sme_divider u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start),
    .num_i(sec_q), .den_i(top_q), .done_o(div_done), .quo_o(quo)
  );
  assign sts_o.div_done = div_done;
  assign sts_o.needs_div = !halt_q && (op_q == sme_pkg::OP_DIV) && !under2 && (top_q != '0);

  // Instruction evaluation.
  always_comb begin
    flt_d = sme_pkg::FLT_NONE; halt_d = 1'b0; ov_d = 1'b0;
    npc_d = pc1; nsp_d = sp_q; swr_d = 1'b0; dwr_d = 1'b0; swa_d = top_a;
    unique case (op_q)
      sme_pkg::OP_LOAD, sme_pkg::OP_LOADI, sme_pkg::OP_IN: begin
        if (full) flt_d = sme_pkg::FLT_OVER;
        else begin
          swr_d = 1'b1; swa_d = SAW'(sp_q); nsp_d = sp_q + SPW'(1);
          if (op_q != sme_pkg::OP_IN) npc_d = pc2;
        end
      end
      sme_pkg::OP_STO: begin
        if (under1) flt_d = sme_pkg::FLT_UNDER;
        else begin dwr_d = 1'b1; npc_d = pc2; end
      end
      sme_pkg::OP_POP: begin
        if (under1) flt_d = sme_pkg::FLT_UNDER;
        else nsp_d = sp_q - SPW'(1);
      end
      sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MULT, sme_pkg::OP_DIV,
      sme_pkg::OP_EQ, sme_pkg::OP_NOTEQ, sme_pkg::OP_GT, sme_pkg::OP_LES,
      sme_pkg::OP_GE, sme_pkg::OP_LE, sme_pkg::OP_AND, sme_pkg::OP_OR: begin
        if (under2) flt_d = sme_pkg::FLT_UNDER;
        else if (op_q == sme_pkg::OP_DIV && top_q == '0) flt_d = sme_pkg::FLT_DIVZ;
        else begin swr_d = 1'b1; swa_d = sec_a; nsp_d = sp_q - SPW'(1); end
      end
      sme_pkg::OP_BR: npc_d = tgt;
      sme_pkg::OP_BRF: begin
        if (under1) flt_d = sme_pkg::FLT_UNDER;
        else begin
          nsp_d = sp_q - SPW'(1);
          npc_d = (top_q == '0) ? tgt : pc2;
        end
      end
      sme_pkg::OP_NOT: begin
        if (under1) flt_d = sme_pkg::FLT_UNDER;
        else swr_d = 1'b1;
      end
      sme_pkg::OP_OUT: begin
        if (under1) flt_d = sme_pkg::FLT_UNDER;
        else begin ov_d = 1'b1; nsp_d = sp_q - SPW'(1); npc_d = pc2; end
      end
      sme_pkg::OP_STOP: begin halt_d = 1'b1; npc_d = pc_q; end
      default: ;
    endcase
    if (flt_d != sme_pkg::FLT_NONE) begin
      halt_d = 1'b1; npc_d = pc_q; nsp_d = sp_q; swr_d = 1'b0; dwr_d = 1'b0; ov_d = 1'b0;
    end
    if (halt_q) begin
      halt_d = 1'b0; npc_d = pc_q; nsp_d = sp_q; swr_d = 1'b0; dwr_d = 1'b0; ov_d = 1'b0;
    end
  end

  // Result value for stack write-back.
  always_comb begin
    unique case (op_q)
      sme_pkg::OP_LOAD:  res_d = dmem_q;
      sme_pkg::OP_LOADI: res_d = imm_q;
      sme_pkg::OP_IN:    res_d = inv_q;
      sme_pkg::OP_ADD:   res_d = sec_q + top_q;
      sme_pkg::OP_SUB:   res_d = sec_q - top_q;
      sme_pkg::OP_MULT:  res_d = mul_q;
      sme_pkg::OP_DIV:   res_d = quo;
      sme_pkg::OP_EQ:    res_d = W'(sec_q == top_q);
      sme_pkg::OP_NOTEQ: res_d = W'(sec_q != top_q);
      sme_pkg::OP_GT:    res_d = W'(sb > sa);
      sme_pkg::OP_LES:   res_d = W'(sb < sa);
      sme_pkg::OP_GE:    res_d = W'(sb >= sa);
      sme_pkg::OP_LE:    res_d = W'(sb <= sa);
      sme_pkg::OP_AND:   res_d = W'((sec_q != '0) && (top_q != '0));
      sme_pkg::OP_OR:    res_d = W'((sec_q != '0) || (top_q != '0));
      sme_pkg::OP_NOT:   res_d = W'(top_q == '0);
      default:           res_d = '0;
    endcase
  end

  // Evaluation results held until commit; product from registered operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      swr_q <= swr_d; dwr_q <= dwr_d; swa_q <= swa_d; npc_q <= npc_d; nsp_q <= nsp_d;
      flt_q <= flt_d; ov_q <= ov_d; was_halt_q <= halt_d;
      mul_q <= sec_q * top_q;
    end
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; sp_q <= '0; halt_q <= 1'b0; sflt_q <= sme_pkg::FLT_NONE;
    end else if (cmd_i.commit && !halt_q) begin
      pc_q <= npc_q; sp_q <= nsp_q;
      if (was_halt_q) halt_q <= 1'b1;
      if (flt_q != sme_pkg::FLT_NONE) sflt_q <= flt_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      o_pc_q  <= AW'(halt_q ? pc_q : npc_q);
      o_ov_q  <= !halt_q && ov_q;
      o_val_q <= (!halt_q && ov_q) ? dmem_q : '0;
      o_h_q   <= halt_q || was_halt_q;
      o_f_q   <= halt_q ? sflt_q : flt_q;
    end
  end

  assign sts_o.halted    = halt_q;
  assign sts_o.out_taken = !out_stall_i;
  assign next_pc_o   = o_pc_q;
  assign out_valid_o = o_ov_q;
  assign out_value_o = o_val_q;
  assign halted_o    = o_h_q;
  assign fault_o     = o_f_q;
endmodule

// ----- rtl/sme_checker.sv -----
// Port-level checker for the stack machine executor, bound to the top level.
module sme_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       halted_o,
  input logic                       out_valid_flag_o,
  input logic [sme_pkg::FaultW-1:0] fault_o
);
  // Never ready for input while a result is pending.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");
  // A result follows an accepted beat, not in the cycle after it.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o) else $error("result too early");
  // A fault always reports halted.
  a_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o != sme_pkg::FLT_NONE) |-> halted_o)
    else $error("fault without halt");
  // Output emission never with a fault.
  a_out_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_valid_flag_o) |-> (fault_o == sme_pkg::FLT_NONE))
    else $error("output beat with fault");
  // Stalled result holds valid.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
endmodule

bind stack_machine_executor_unit sme_checker u_sme_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .halted_o, .out_valid_flag_o, .fault_o
);
